### design/pads_pkg.sv
package pads_pkg;

	localparam int unsigned DivW     = 48;
	localparam int unsigned DivCntW  = 6;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 32;

	localparam logic [31:0] LowBandHz   = 32'd2000000;
	localparam logic [47:0] DivMinFixed = 48'd256;
	localparam logic [47:0] DivMaxFixed = 48'd16640000;

	localparam logic [25:0] CrystalRst   = 26'd12000350;
	localparam logic [31:0] VcoMinRst    = 32'd400000000;
	localparam logic [31:0] VcoMaxRst    = 32'd1200000000;
	localparam logic [31:0] SysMinRst    = 32'd100000000;
	localparam logic [31:0] SysMaxRst    = 32'd133000000;
	localparam logic [31:0] TargetMinRst = 32'd100000;
	localparam logic [31:0] TargetMaxRst = 32'd33250000;

	localparam logic [7:0] FbFirst = 8'd30;
	localparam logic [7:0] FbLast  = 8'd150;
	localparam logic [2:0] P1First = 3'd2;
	localparam logic [2:0] P1Last  = 3'd6;
	localparam logic [1:0] P2First = 2'd1;
	localparam logic [1:0] P2Last  = 2'd2;
	localparam logic [7:0] FbLow   = 8'd80;
	localparam logic [2:0] P1Low   = 3'd4;
	localparam logic [1:0] P2Low   = 2'd2;
	localparam logic [7:0] FbFall  = 8'd95;
	localparam logic [2:0] P1Fall  = 3'd5;
	localparam logic [1:0] P2Fall  = 2'd2;

	typedef enum logic [2:0] {
		CFG_CRYSTAL    = 3'd0,
		CFG_VCO_MIN    = 3'd1,
		CFG_VCO_MAX    = 3'd2,
		CFG_SYS_MIN    = 3'd3,
		CFG_SYS_MAX    = 3'd4,
		CFG_TARGET_MIN = 3'd5,
		CFG_TARGET_MAX = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PATH_LOW    = 2'd0,
		PATH_SEARCH = 2'd1,
		PATH_FALL   = 2'd2
	} path_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CLAMP, S_MUL, S_CHKV, S_DSYS, S_CHKS, S_DCD, S_CHKC, S_DRB,
		S_NEXT, S_FMUL, S_FGO, S_FD1, S_FGO2, S_FD2, S_OUT
	} state_t;

	typedef struct packed {
		logic            start;
		logic [DivW-1:0] num;
		logic [DivW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DivW-1:0] quot;
	} div_rsp_t;

endpackage

### design/pads_if.sv
interface pads_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] target_hz;
	modport source(output valid, output target_hz, input ready);
	modport sink(input valid, input target_hz, output ready);
endinterface

interface pads_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  feedback_div;
	logic [2:0]  post_div_one;
	logic [1:0]  post_div_two;
	logic [31:0] sys_clock_hz;
	logic [15:0] div_int;
	logic [7:0]  frac_div;
	logic [1:0]  path_taken;
	logic [31:0] search_error_hz;
	modport source(output valid, output feedback_div, output post_div_one,
		output post_div_two, output sys_clock_hz, output div_int, output frac_div,
		output path_taken, output search_error_hz, input ready);
	modport sink(input valid, input feedback_div, input post_div_one,
		input post_div_two, input sys_clock_hz, input div_int, input frac_div,
		input path_taken, input search_error_hz, output ready);
endinterface

### design/pads_div.sv
module pads_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pads_pkg::div_req_t dreq,
	output pads_pkg::div_rsp_t drsp
);

	logic [pads_pkg::DivCntW-1:0] cnt_q;
	logic                         done_q;
	logic [pads_pkg::DivW-1:0]    rem_q;
	logic [pads_pkg::DivW-1:0]    quo_q;
	logic [pads_pkg::DivW-1:0]    den_q;
	logic [pads_pkg::DivW:0]      trial;
	logic                         fits;

	assign trial = {rem_q, quo_q[pads_pkg::DivW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !dreq.start && (cnt_q == pads_pkg::DivCntW'(1));
			if (dreq.start) begin
				cnt_q <= pads_pkg::DivCntW'(pads_pkg::DivW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (dreq.start) begin
			rem_q <= '0;
			quo_q <= dreq.num;
			den_q <= dreq.den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? pads_pkg::DivW'(trial - {1'b0, den_q}) : trial[pads_pkg::DivW-1:0];
			quo_q <= {quo_q[pads_pkg::DivW-2:0], fits};
		end
	end

	assign drsp.done = done_q;
	assign drsp.quot = quo_q;

endmodule

### design/pll_and_clock_divider_search.sv
// A request on the low band skips the search, and a zero clamped request also skips the
// second divider pass. A search visits each of the 1210 candidates in turn and needs up to
// three divider passes for each, as its range checks allow, and then two passes at the end.
// Throughput: one item at a time; the input is ready again the cycle after the result
// register loads, and waits while a previous result has not been transferred.
// Reset (arst_n low) restores the configuration defaults, idles the sequencer, empties the output.
module pll_and_clock_divider_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pads_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [pads_pkg::CfgDataW-1:0]     cfg_data,
	pads_in_if.sink                           req,
	pads_out_if.source                        rsp
);

	logic [25:0] crystal_q;
	logic [31:0] vco_min_q, vco_max_q, sys_min_q, sys_max_q, tmin_q, tmax_q;

	pads_pkg::state_t   state_q, state_d;
	pads_pkg::div_req_t dreq;
	pads_pkg::div_rsp_t drsp;

	logic [31:0] target_q;
	logic [33:0] pio_q;
	logic [7:0]  fb_q, bfb_q;
	logic [2:0]  a_q, ba_q;
	logic [1:0]  b_q, bb_q;
	logic        found_q;
	logic [47:0] best_q;
	logic [33:0] vco_q;
	logic [33:0] sys_q;
	logic [47:0] cd_q;
	logic [1:0]  path_q;

	logic [31:0] clamped;
	logic [3:0]  ab;
	logic [47:0] err;
	logic        last;
	logic        vco_ok, sys_ok, cd_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crystal_q <= pads_pkg::CrystalRst;
			vco_min_q <= pads_pkg::VcoMinRst;
			vco_max_q <= pads_pkg::VcoMaxRst;
			sys_min_q <= pads_pkg::SysMinRst;
			sys_max_q <= pads_pkg::SysMaxRst;
			tmin_q    <= pads_pkg::TargetMinRst;
			tmax_q    <= pads_pkg::TargetMaxRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pads_pkg::CFG_CRYSTAL:    crystal_q <= cfg_data[25:0];
				pads_pkg::CFG_VCO_MIN:    vco_min_q <= cfg_data;
				pads_pkg::CFG_VCO_MAX:    vco_max_q <= cfg_data;
				pads_pkg::CFG_SYS_MIN:    sys_min_q <= cfg_data;
				pads_pkg::CFG_SYS_MAX:    sys_max_q <= cfg_data;
				pads_pkg::CFG_TARGET_MIN: tmin_q    <= cfg_data;
				pads_pkg::CFG_TARGET_MAX: tmax_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		clamped = req.target_hz;
		if (clamped < tmin_q) clamped = tmin_q;
		if (clamped > tmax_q) clamped = tmax_q;
	end

	assign ab     = {1'b0, a_q} * {2'b0, b_q};
	assign vco_ok = (vco_q >= {2'b0, vco_min_q}) && (vco_q <= {2'b0, vco_max_q});
	assign sys_ok = (sys_q >= {2'b0, sys_min_q}) && (sys_q <= {2'b0, sys_max_q});
	assign cd_ok  = (cd_q >= pads_pkg::DivMinFixed) && (cd_q <= pads_pkg::DivMaxFixed);
	assign err    = ({16'b0, target_q} > drsp.quot) ? ({16'b0, target_q} - drsp.quot)
		: (drsp.quot - {16'b0, target_q});
	assign last   = (a_q == pads_pkg::P1Last) && (b_q == pads_pkg::P2Last)
		&& (fb_q == pads_pkg::FbLast);

	pads_div u_div (.clk(clk), .arst_n(arst_n), .dreq(dreq), .drsp(drsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pads_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		req.ready  = 1'b0;
		unique case (state_q)
			pads_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = pads_pkg::S_CLAMP;
			end
			pads_pkg::S_CLAMP:
				state_d = (target_q >= pads_pkg::LowBandHz) ? pads_pkg::S_MUL : pads_pkg::S_FMUL;
			pads_pkg::S_MUL: state_d = pads_pkg::S_CHKV;
			pads_pkg::S_CHKV: begin
				if (vco_ok) begin
					dreq.start = 1'b1;
					dreq.num   = {14'b0, vco_q};
					dreq.den   = {44'b0, ab};
					state_d    = pads_pkg::S_DSYS;
				end else begin
					state_d = pads_pkg::S_NEXT;
				end
			end
			pads_pkg::S_DSYS: if (drsp.done) state_d = pads_pkg::S_CHKS;
			pads_pkg::S_CHKS: begin
				if (sys_ok && pio_q != '0) begin
					dreq.start = 1'b1;
					dreq.num   = {6'b0, sys_q, 8'b0};
					dreq.den   = {14'b0, pio_q};
					state_d    = pads_pkg::S_DCD;
				end else begin
					state_d = pads_pkg::S_NEXT;
				end
			end
			pads_pkg::S_DCD: if (drsp.done) state_d = pads_pkg::S_CHKC;
			pads_pkg::S_CHKC: begin
				if (cd_ok) begin
					dreq.start = 1'b1;
					dreq.num   = {8'b0, sys_q, 6'b0};
					dreq.den   = cd_q;
					state_d    = pads_pkg::S_DRB;
				end else begin
					state_d = pads_pkg::S_NEXT;
				end
			end
			pads_pkg::S_DRB: if (drsp.done) state_d = pads_pkg::S_NEXT;
			pads_pkg::S_NEXT: state_d = last ? pads_pkg::S_FMUL : pads_pkg::S_MUL;
			pads_pkg::S_FMUL: state_d = pads_pkg::S_FGO;
			pads_pkg::S_FGO: begin
				dreq.start = 1'b1;
				dreq.num   = {14'b0, vco_q};
				dreq.den   = {44'b0, ab};
				state_d    = pads_pkg::S_FD1;
			end
			pads_pkg::S_FD1: if (drsp.done) state_d = pads_pkg::S_FGO2;
			pads_pkg::S_FGO2: begin
				if (pio_q != '0) begin
					dreq.start = 1'b1;
					dreq.num   = {6'b0, sys_q, 8'b0};
					dreq.den   = {14'b0, pio_q};
					state_d    = pads_pkg::S_FD2;
				end else begin
					state_d = pads_pkg::S_OUT;
				end
			end
			pads_pkg::S_FD2: if (drsp.done) state_d = pads_pkg::S_OUT;
			pads_pkg::S_OUT: if (!rsp.valid || rsp.ready) state_d = pads_pkg::S_IDLE;
			default: state_d = pads_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			path_q  <= pads_pkg::PATH_LOW;
		end else begin
			unique case (state_q)
				pads_pkg::S_CLAMP: begin
					found_q <= 1'b0;
					path_q  <= pads_pkg::PATH_LOW;
				end
				pads_pkg::S_DRB:
					if (drsp.done && (!found_q || err < best_q)) found_q <= 1'b1;
				pads_pkg::S_NEXT:
					if (last) path_q <= found_q ? pads_pkg::PATH_SEARCH : pads_pkg::PATH_FALL;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pads_pkg::S_IDLE: begin
				target_q <= clamped;
				pio_q    <= {clamped, 2'b0};
			end
			pads_pkg::S_CLAMP: begin
				best_q <= '0;
				if (target_q >= pads_pkg::LowBandHz) begin
					fb_q <= pads_pkg::FbFirst;
					a_q  <= pads_pkg::P1First;
					b_q  <= pads_pkg::P2First;
				end else begin
					fb_q <= pads_pkg::FbLow;
					a_q  <= pads_pkg::P1Low;
					b_q  <= pads_pkg::P2Low;
				end
			end
			pads_pkg::S_MUL, pads_pkg::S_FMUL: vco_q <= {26'b0, fb_q} * {8'b0, crystal_q};
			pads_pkg::S_DSYS, pads_pkg::S_FD1: if (drsp.done) sys_q <= drsp.quot[33:0];
			pads_pkg::S_DCD: if (drsp.done) cd_q <= drsp.quot;
			pads_pkg::S_DRB: begin
				if (drsp.done && (!found_q || err < best_q)) begin
					best_q <= err;
					bfb_q  <= fb_q;
					ba_q   <= a_q;
					bb_q   <= b_q;
				end
			end
			pads_pkg::S_NEXT: begin
				if (last) begin
					fb_q <= found_q ? bfb_q : pads_pkg::FbFall;
					a_q  <= found_q ? ba_q : pads_pkg::P1Fall;
					b_q  <= found_q ? bb_q : pads_pkg::P2Fall;
					if (!found_q) best_q <= '0;
				end else if (fb_q != pads_pkg::FbLast) begin
					fb_q <= fb_q + 1'b1;
				end else begin
					fb_q <= pads_pkg::FbFirst;
					if (b_q == pads_pkg::P2First) begin
						b_q <= pads_pkg::P2Last;
					end else begin
						b_q <= pads_pkg::P2First;
						a_q <= a_q + 1'b1;
					end
				end
			end
			pads_pkg::S_FGO2: if (pio_q == '0) cd_q <= 48'hFFFFFF;
			pads_pkg::S_FD2:
				if (drsp.done)
					cd_q <= (drsp.quot < pads_pkg::DivMinFixed) ? pads_pkg::DivMinFixed : drsp.quot;
			default: ;
		endcase
	end

	// output register, loaded when the previous result has been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (state_q == pads_pkg::S_OUT && (!rsp.valid || rsp.ready)) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pads_pkg::S_OUT && (!rsp.valid || rsp.ready)) begin
			rsp.feedback_div    <= fb_q;
			rsp.post_div_one    <= a_q;
			rsp.post_div_two    <= b_q;
			rsp.sys_clock_hz    <= sys_q[31:0];
			rsp.div_int         <= cd_q[23:8];
			rsp.frac_div        <= cd_q[7:0];
			rsp.path_taken      <= path_q;
			rsp.search_error_hz <= best_q[31:0];
		end
	end

endmodule

### design/pads_chk.sv
module pads_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [7:0]  feedback_div,
	input logic [2:0]  post_div_one,
	input logic [1:0]  post_div_two,
	input logic [1:0]  path_taken,
	input logic [31:0] search_error_hz
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transfer");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input ready right after a transfer");

	a_post: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> post_div_one >= 3'd2 && post_div_one <= 3'd6
			&& post_div_two >= 2'd1 && post_div_two <= 2'd2)
		else $error("post divider out of range");

	a_fb: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> feedback_div >= 8'd30 && feedback_div <= 8'd150)
		else $error("feedback divider out of range");

	a_path: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> path_taken != 2'd3 && (path_taken == 2'd1 || search_error_hz == '0))
		else $error("bad path or error on a non-search path");

endmodule

bind pll_and_clock_divider_search pads_chk u_pads_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.feedback_div(rsp.feedback_div), .post_div_one(rsp.post_div_one),
	.post_div_two(rsp.post_div_two), .path_taken(rsp.path_taken),
	.search_error_hz(rsp.search_error_hz)
);
